@@ src/fwrl_pkg.sv @@
// Shared types and constants for the fixed-window rate limiter.
// No dependencies; imported by fwrl_ctrl, fwrl_dp and the top level.
`timescale 1ns / 1ps

package fwrl_pkg;

  localparam int unsigned KEY_COUNT       = 1024;  // power of two
  localparam int unsigned KEY_W           = $clog2(KEY_COUNT);
  localparam int unsigned KEY_FIELD_W     = 10;
  localparam int unsigned LIMIT_W         = 16;
  localparam int unsigned SEC_W           = 17;
  localparam int unsigned SECONDS_PER_DAY = 86400;
  localparam int unsigned LIMIT_RESET     = 10;
  localparam int unsigned WINDOW_RESET    = 60;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned S_TDATA_W   = 16;  // key_index padded to bytes
  localparam int unsigned M_TDATA_W   = 24;  // allowed, count_now padded

  localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_LIMIT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SECONDS = 8'd1;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // one table entry
  typedef struct packed {
    logic               valid;
    logic [SEC_W-1:0]   window;
    logic [LIMIT_W-1:0] count;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic             clear;     // write an invalid entry at clr_addr
    logic [KEY_W-1:0] clr_addr;
    logic             tick;      // advance time by one second
    logic             lookup;    // read entry for incoming key
    logic             update;    // decide, write back, load output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_stall;  // output register full and not taken
  } status_t;

endpackage

@@ src/fwrl_ctrl.sv @@
// Controller FSM: clearing sweep after reset, accept and update sequencing.
// Depends on fwrl_pkg.
`timescale 1ns / 1ps

module fwrl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  input  fwrl_pkg::status_t sts_i,
  output fwrl_pkg::cmd_t    cmd_o
);
  import fwrl_pkg::*;

  state_e           state_q, state_d;
  logic [KEY_W-1:0] clr_q, clr_d;
  logic             accept;
  logic             last_clr;

  assign last_clr = (clr_q == KEY_W'(KEY_COUNT - 1));
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (last_clr) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (in_kind_i == KIND_REQUEST)) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts_i.out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.clear     = (state_q == ST_CLEAR);
    cmd_o.clr_addr  = clr_q;
    cmd_o.tick      = accept && (in_kind_i == KIND_TICK);
    cmd_o.lookup    = accept && (in_kind_i == KIND_REQUEST);
    cmd_o.update    = (state_q == ST_UPDATE) && !sts_i.out_stall;
    clr_d           = (state_q == ST_CLEAR) ? clr_q + KEY_W'(1) : clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

endmodule

@@ src/fwrl_dp.sv @@
// Datapath: config registers, time-of-day/window counters, key table,
// per-request decision and output register. Depends on fwrl_pkg.
`timescale 1ns / 1ps

module fwrl_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fwrl_pkg::cmd_t                      cmd_i,
  output fwrl_pkg::status_t                   sts_o,
  input  logic [fwrl_pkg::KEY_FIELD_W-1:0]    key_i,
  input  logic                                cfg_we_i,
  input  logic [fwrl_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [fwrl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_allowed_o,
  output logic [fwrl_pkg::LIMIT_W-1:0]        out_count_o
);
  import fwrl_pkg::*;

  // config
  logic [LIMIT_W-1:0] limit_q;
  logic [SEC_W-1:0]   window_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LIMIT_W'(LIMIT_RESET);
      window_len_q <= SEC_W'(WINDOW_RESET);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_REQUEST_LIMIT)  limit_q      <= cfg_data_i[LIMIT_W-1:0];
      if (cfg_index_i == CFG_WINDOW_SECONDS) window_len_q <= cfg_data_i[SEC_W-1:0];
    end
  end

  // time keeping
  logic [SEC_W-1:0] sod_q, sod_d, siw_q, siw_d, win_q, win_d;
  logic [SEC_W-1:0] len, sod_inc, siw_inc;

  always_comb begin
    len     = (window_len_q == '0) ? SEC_W'(1) : window_len_q;
    sod_inc = sod_q + SEC_W'(1);
    siw_inc = siw_q + SEC_W'(1);
    sod_d   = sod_q;
    siw_d   = siw_q;
    win_d   = win_q;
    if (cmd_i.tick) begin
      if (sod_inc >= SEC_W'(SECONDS_PER_DAY)) begin
        sod_d = '0;
        siw_d = '0;
        win_d = '0;
      end else begin
        sod_d = sod_inc;
        if (siw_inc >= len) begin
          siw_d = '0;
          win_d = win_q + SEC_W'(1);
        end else begin
          siw_d = siw_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sod_q <= '0;
      siw_q <= '0;
      win_q <= '0;
    end else begin
      sod_q <= sod_d;
      siw_q <= siw_d;
      win_q <= win_d;
    end
  end

  // key table, single port
  entry_t           mem [KEY_COUNT];
  entry_t           rdata_q;
  logic [KEY_W-1:0] key_q;
  entry_t           wdata;
  logic             we;
  logic [KEY_W-1:0] waddr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      rdata_q <= mem[key_i[KEY_W-1:0]];
      key_q   <= key_i[KEY_W-1:0];
    end
  end

  // decision
  logic [LIMIT_W-1:0] limit;
  logic               hit;
  logic               allowed;
  logic [LIMIT_W-1:0] count_new;

  always_comb begin
    limit = (limit_q == '0) ? LIMIT_W'(1) : limit_q;
    hit   = rdata_q.valid && (rdata_q.window == win_q);
    if (!hit) begin
      allowed   = 1'b1;
      count_new = LIMIT_W'(1);
    end else if (rdata_q.count >= limit) begin
      allowed   = 1'b0;
      count_new = rdata_q.count;
    end else begin
      allowed   = 1'b1;
      count_new = rdata_q.count + LIMIT_W'(1);
    end
  end

  always_comb begin
    we           = cmd_i.clear || cmd_i.update;
    waddr        = cmd_i.clear ? cmd_i.clr_addr : key_q;
    wdata.valid  = !cmd_i.clear;
    wdata.window = win_q;
    wdata.count  = count_new;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  // output register
  logic               out_valid_q;
  logic               out_allowed_q;
  logic [LIMIT_W-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_allowed_q <= allowed;
      out_count_q   <= count_new;
    end
  end

  assign sts_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_allowed_o   = out_allowed_q;
  assign out_count_o     = out_count_q;

endmodule

@@ src/fixed_window_rate_limiter.sv @@
// Top level of the fixed-window rate limiter: joins controller and datapath.
// Depends on fwrl_pkg, fwrl_ctrl and fwrl_dp.
`timescale 1ns / 1ps

// Usage
//  s_axis: one word per item. tuser = kind (0 request, 1 one-second tick),
//          tdata[9:0] = key_index. Ticks give no result.
//  m_axis: one word per request. tdata[0] = allowed, tdata[16:1] = count_now.
//  cfg:    write channel, always ready. Index 0 = request_limit,
//          index 1 = window_seconds, other indexes ignored. Write only while
//          no request is in flight.
//  Reset:  limit 10, window 60 s, time at midnight. After reset a clearing
//          sweep invalidates the 1024-entry key table, one entry a cycle, so
//          s_axis_tready stays low until the sweep ends; cfg writes still land.
//  Flow:   after a tick a new word may follow at once. A request's table
//          read is registered at accept; the decision and write-back happen
//          in the update state, which also loads the result into the output
//          register, and that state waits while the output register is full
//          and not taken. s_axis_tready stays low from accept until the update,
//          so a request is finished before the next word is taken.
//  Stall:  while a result waits, ticks and one more request are accepted;
//          that request's update holds until the output register frees.

module fixed_window_rate_limiter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [fwrl_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,   // [9:0] key_index
  input  logic                              s_axis_tuser_i,   // [0] kind
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [fwrl_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,   // [0] allowed, [16:1] count_now
  // config writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fwrl_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [fwrl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import fwrl_pkg::*;

  cmd_t               cmd;
  status_t            sts;
  logic               out_allowed;
  logic [LIMIT_W-1:0] out_count;

  assign cfg_ready_o = 1'b1;

  fwrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fwrl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .key_i         (s_axis_tdata_i[KEY_FIELD_W-1:0]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_allowed_o (out_allowed),
    .out_count_o   (out_count)
  );

  // pack result word, zero pad to bytes
  assign m_axis_tdata_o = {{(M_TDATA_W - LIMIT_W - 1){1'b0}}, out_count, out_allowed};

endmodule

@@ bench/fwrl_verdict_check.sv @@
// Result checker for the fixed-window rate limiter: tracks time, windows and
// per-key counts from the accepted input and config words. Depends on fwrl_pkg.
`timescale 1ns / 1ps

module fwrl_verdict_check
  import fwrl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata_i,   // [9:0] key_index
  input  logic                   s_axis_tuser_i,   // [0] kind
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [M_TDATA_W-1:0]   m_axis_tdata_i,   // [0] allowed, [16:1] count_now
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            verdicts_due_o
);

  typedef struct packed {
    logic               allowed;
    logic [LIMIT_W-1:0] count_now;
  } verdict_t;

  logic [LIMIT_W-1:0] limit_q;
  logic [SEC_W-1:0]   win_len_q;
  logic               key_seen [KEY_COUNT];
  logic [SEC_W-1:0]   key_win  [KEY_COUNT];
  logic [LIMIT_W-1:0] key_cnt  [KEY_COUNT];
  logic [SEC_W-1:0]   day_sec;
  logic [SEC_W-1:0]   win_sec;
  logic [SEC_W-1:0]   win_num;
  verdict_t           due_verdicts [$];
  int unsigned        fails;

  // one second passes; window rolls by counting, day rolls at midnight
  function automatic void step_clock();
    logic [SEC_W-1:0] len;
    len = (win_len_q == '0) ? SEC_W'(1) : win_len_q;
    if (day_sec + 1 >= SECONDS_PER_DAY) begin
      day_sec = '0;
      win_sec = '0;
      win_num = '0;
    end else begin
      day_sec = day_sec + 1'b1;
      win_sec = win_sec + 1'b1;
      if (win_sec >= len) begin
        win_sec = '0;
        win_num = win_num + 1'b1;
      end
    end
  endfunction

  function automatic verdict_t judge_request(logic [KEY_W-1:0] slot);
    logic [LIMIT_W-1:0] cap;
    verdict_t           v;
    cap = (limit_q == '0) ? LIMIT_W'(1) : limit_q;
    if (!key_seen[slot] || key_win[slot] != win_num) begin
      key_seen[slot] = 1'b1;
      key_win[slot]  = win_num;
      key_cnt[slot]  = LIMIT_W'(1);
      v.allowed      = 1'b1;
    end else if (key_cnt[slot] >= cap) begin
      v.allowed = 1'b0;
    end else begin
      key_cnt[slot] = key_cnt[slot] + 1'b1;
      v.allowed     = 1'b1;
    end
    v.count_now = key_cnt[slot];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      limit_q   = LIMIT_W'(LIMIT_RESET);
      win_len_q = SEC_W'(WINDOW_RESET);
      day_sec   = '0;
      win_sec   = '0;
      win_num   = '0;
      fails     = 0;
      due_verdicts.delete();
      for (int k = 0; k < KEY_COUNT; k++) begin
        key_seen[k] = 1'b0;
        key_win[k]  = '0;
        key_cnt[k]  = '0;
      end
      mismatch_count_o <= 0;
      verdicts_due_o   <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_verdicts.size() == 0) begin
          $error("result word %h with no request pending", m_axis_tdata_i);
          fails++;
        end else begin
          want = due_verdicts.pop_front();
          if (m_axis_tdata_i[0] !== want.allowed) begin
            $error("allowed: expected %0d, actual %0d", want.allowed, m_axis_tdata_i[0]);
            fails++;
          end
          if (m_axis_tdata_i[LIMIT_W:1] !== want.count_now) begin
            $error("count_now: expected %0d, actual %0d", want.count_now,
                   m_axis_tdata_i[LIMIT_W:1]);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_REQUEST_LIMIT:  limit_q = cfg_data_i[LIMIT_W-1:0];
          CFG_WINDOW_SECONDS: win_len_q = cfg_data_i[SEC_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == KIND_TICK) begin
          step_clock();
        end else begin
          due_verdicts.push_back(
            judge_request(KEY_W'(s_axis_tdata_i[KEY_FIELD_W-1:0] % KEY_COUNT)));
        end
      end
      mismatch_count_o <= fails;
      verdicts_due_o   <= due_verdicts.size();
    end
  end

endmodule

@@ bench/tb_fixed_window_rate_limiter.sv @@
// Testbench top for the fixed-window rate limiter: clock, reset, stimulus and
// verdict. Depends on fwrl_pkg, fixed_window_rate_limiter and fwrl_verdict_check.
`timescale 1ns / 1ps

module tb_fixed_window_rate_limiter;
  import fwrl_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 8'hFF;  // unmapped, must be ignored
  localparam int unsigned IDLE_PCT      = 21;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 125;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic                   s_tuser   = KIND_REQUEST;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   calm      = 1'b0;  // no idling on either side while set
  int unsigned            mismatches;
  int unsigned            verdicts_due;

  always #5 clk_i = ~clk_i;

  fixed_window_rate_limiter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  fwrl_verdict_check verdict_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tuser_i   (s_tuser),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .verdicts_due_o   (verdicts_due)
  );

  // result side back-pressure, off during the calm stretch
  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // One input word. Random idle cycles go in front of it; valid stays high
  // from one word to the next when no idle cycle falls between them.
  task automatic send_word(input logic kind, input logic [KEY_FIELD_W-1:0] key);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= S_TDATA_W'(key);
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic request(input logic [KEY_FIELD_W-1:0] key);
    send_word(KIND_REQUEST, key);
  endtask

  // key field is don't-care on a tick, so fill it with noise
  task automatic tick();
    send_word(KIND_TICK, KEY_FIELD_W'($urandom));
  endtask

  // Stop the input stream and wait until every request has answered. A tick
  // leaves no result, so a few extra cycles let a trailing one retire before
  // any config write.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // caller lowers cfg_valid once the burst of writes is done
  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] limit,
                           input logic [CFG_DATA_W-1:0] window);
    set_reg(CFG_REQUEST_LIMIT, limit);
    set_reg(CFG_WINDOW_SECONDS, window);
    cfg_valid <= 1'b0;
  endtask

  // Mostly requests to a handful of keys so quotas fill and windows roll;
  // one request in five goes anywhere in the table.
  task automatic random_phase(input int unsigned items, input int unsigned tick_pct);
    logic [KEY_FIELD_W-1:0] key;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        tick();
      end else begin
        if ($urandom_range(0, 4) == 0) key = KEY_FIELD_W'($urandom);
        else key = KEY_FIELD_W'($urandom_range(0, 7));
        request(key);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // write to an unmapped index while the key table is still being cleared
    set_reg(CFG_SPARE, '1);
    cfg_valid <= 1'b0;

    // reset settings: fresh keys, index extremes, a tick, a repeat key
    request('0);
    request('1);
    request(10'h155);
    request(10'h2AA);
    tick();
    request('0);

    // quota of two, one-second windows: deny, then fresh after a tick
    drain();
    configure(17'd2, 17'd1);
    request(10'd5);
    request(10'd5);
    request(10'd5);
    tick();
    request(10'd5);

    // zero limit acts as one, zero window length acts as one second
    drain();
    configure(17'd0, 17'd0);
    request(10'd6);
    request(10'd6);
    tick();
    request(10'd6);

    // window longer than a day holds still; then the limit drops below
    // the count already reached
    drain();
    configure(17'd6, 17'h1FFFF);
    request(10'd9);
    request(10'd9);
    request(10'd9);
    request(10'd9);
    drain();
    configure(17'd2, 17'h1FFFF);
    request(10'd9);

    // window shortened after three seconds: ends on the next tick
    drain();
    configure(17'd10, 17'd5);
    tick();
    tick();
    tick();
    drain();
    configure(17'd10, 17'd2);
    tick();
    request(10'd9);

    // random traffic over several settings, extremes included
    drain();
    configure(17'd1, 17'd1);
    random_phase(PHASE_ITEMS, 20);
    drain();
    configure(17'h1FFFF, 17'd86400);  // top bit dropped: limit of 65535
    random_phase(PHASE_ITEMS, 10);
    drain();
    configure(17'd4, 17'd3);
    random_phase(PHASE_ITEMS, 25);

    // long stretch with no idling on either side, short windows
    drain();
    configure(17'd3, 17'd1);
    calm <= 1'b1;
    random_phase(PHASE_ITEMS, 40);
    drain();
    calm <= 1'b0;

    configure(17'd0, 17'd0);
    random_phase(PHASE_ITEMS, 15);
    drain();
    configure(17'd3, 17'h1FFFF);
    random_phase(PHASE_ITEMS, 10);
    drain();
    configure(17'd10, 17'd60);
    random_phase(PHASE_ITEMS, 30);

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard, many times the longest plausible run
  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
